@@ rtl/pkts_pkg.sv @@
// Shared types, constants and codes for the packed keyed table.
package pkts_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int KEY_W       = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ACT_W       = 2;
   localparam int STAT_W      = 2;

   // Request actions
   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

   // One stored table entry
   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [DATA_WIDTH-1:0] value;
   } entry_type;

   // One incoming request
   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic [KEY_W-1:0]      entity;
      logic [ACT_W-1:0]      action;
   } req_type;

   // One finished response
   typedef struct packed {
      logic [CNT_W-1:0]      count;
      logic [STAT_W-1:0]     status;
      logic [DATA_WIDTH-1:0] value_out;
      logic                  found;
   } res_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/pkts_store.sv @@
// Entry memory: one write port, one read port, registered read data.
module pkts_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [pkts_pkg::IDX_W-1:0]  wr_addr,
   input  pkts_pkg::entry_type         wr_data,
   input  logic [pkts_pkg::IDX_W-1:0]  rd_addr,
   output pkts_pkg::entry_type         rd_data
);
   import pkts_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pkts_seq.sv @@
// Operation sequencer: linear key search, append and swap-remove.
module pkts_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pkts_pkg::req_type           req_item,
   input  logic                        out_free,
   output logic                        res_valid,
   output pkts_pkg::res_type           res_item,
   output logic                        wr_en,
   output logic [pkts_pkg::IDX_W-1:0]  wr_addr,
   output pkts_pkg::entry_type         wr_data,
   output logic [pkts_pkg::IDX_W-1:0]  rd_addr,
   input  pkts_pkg::entry_type         rd_data
);
   import pkts_pkg::*;

   state_type             state_ff, state_in;
   logic [ACT_W-1:0]      act_ff, act_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      hit_ff, hit_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  found_ff, found_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [STAT_W-1:0]     status_ff, status_in;

   logic                  key_hit;
   logic                  table_full;
   logic [CNT_W-1:0]      idx_next;
   logic [IDX_W-1:0]      last_idx;
   logic [CNT_W-1:0]      count_dec;

   assign key_hit    = (rd_data.key == key_ff);
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign idx_next   = {1'b0, idx_ff} + CNT_W'(1);
   assign count_dec  = count_ff - CNT_W'(1);
   assign last_idx   = count_dec[IDX_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_item.action == ACT_LOOKUP || req_item.action == ACT_REMOVE)
                   && count_ff != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (key_hit) begin
               state_in = (act_ff == ACT_REMOVE) ? ST_MOVE : ST_DONE;
            end else if (idx_next == count_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_MOVE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      act_in    = act_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      val_in    = val_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[IDX_W-1:0];
      wr_data   = '{key: req_item.entity, value: req_item.value};
      rd_addr   = idx_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               act_in    = req_item.action;
               key_in    = req_item.entity;
               idx_in    = '0;
               found_in  = 1'b0;
               val_in    = '0;
               status_in = STAT_OK;
               case (req_item.action)
                  ACT_ADD: begin
                     if (table_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        found_in = 1'b1;
                     end
                  end
                  ACT_LOOKUP, ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_MISS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // rd_data holds entry idx_ff
            if (key_hit) begin
               if (act_ff == ACT_REMOVE) begin
                  hit_in  = idx_ff;
                  rd_addr = last_idx;
               end else begin
                  found_in = 1'b1;
                  val_in   = rd_data.value;
               end
            end else if (idx_next == count_ff) begin
               status_in = STAT_MISS;
            end else begin
               idx_in  = idx_next[IDX_W-1:0];
               rd_addr = idx_next[IDX_W-1:0];
            end
         end
         ST_MOVE: begin
            // rd_data holds the last entry; drop it into the hole
            wr_en    = 1'b1;
            wr_addr  = hit_ff;
            wr_data  = rd_data;
            count_in = count_dec;
            found_in = 1'b1;
         end
         ST_DONE: res_valid = out_free;
         default: ;
      endcase
   end

   assign res_item = '{count: count_ff, status: status_ff, value_out: val_ff,
                       found: found_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Operation context and result
   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      found_ff  <= found_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> ({1'b0, idx_ff} < count_ff))
      else $error("scan index beyond packed entries");

   a_move_after_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOVE |-> $past(state_ff) == ST_SCAN && act_ff == ACT_REMOVE
                              && count_ff != '0)
      else $error("swap move without a remove hit");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(wr_en))
      else $error("entry count changed without a table write");

endmodule

@@ rtl/packed_keyed_table_swap_remove_top.sv @@
// Top level of the packed keyed table with swap-remove.
//
//  channel  | direction | tdata fields (low bit up)
//  ---------+-----------+------------------------------------------------
//  req_     | in        | action[1:0] entity[17:2] value[49:18], pad to 56
//  rsp_     | out       | found[0] value_out[32:1] status[34:33] count[41:35]
//
//  Add, full-table add and unknown actions go from accept straight to the
//  response. Lookup and remove read entries in order (none on an empty
//  table, else from one up to the entry count), and a remove hit then adds
//  a move of the last entry into the hole. The single-port read of the
//  entry memory, one entry per cycle, sets the search time.
//  Reset is synchronous and clears the entry count; stored entries keep
//  their contents. A response waits in the output register while the
//  next request is accepted; a stall on rsp_ holds the sequencer only
//  when a second response is ready.
module packed_keyed_table_swap_remove_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // action[1:0], entity[17:2], value[49:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // found[0], value_out[32:1], status[34:33],
                                    // count[41:35]
);
   import pkts_pkg::*;

   localparam int REQ_BITS = $bits(req_type);
   localparam int RSP_BITS = $bits(res_type);

   req_type    req_item;
   res_type    res_item;
   logic       res_valid;
   logic       out_free;
   logic       wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   entry_type  wr_data;
   entry_type  rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   res_type    rsp_data_ff, rsp_data_in;

   assign req_item = req_tdata[REQ_BITS-1:0];

   pkts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_item  (res_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   pkts_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(48 - RSP_BITS)'(0), rsp_data_ff};

   // Checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !res_valid)
      else $error("response register overwritten while stalled");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_tready)
      else $error("request taken while a response is being issued");

   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> rsp_tvalid)
      else $error("issued response not held in output register");

endmodule

@@ verif/packed_keyed_table_swap_remove_top_tb.sv @@
// Self-checking testbench for the packed keyed table with swap-remove.
`timescale 1ns / 1ps

module packed_keyed_table_swap_remove_top_tb;
   import pkts_pkg::*;

   // Unused action code, must act as a no-op
   localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

   localparam int RANDOM_ITEMS  = 1000;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;    // action[1:0], entity[17:2], value[49:18]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // found[0], value_out[32:1], status[34:33],
                                   // count[41:35]

   packed_keyed_table_swap_remove_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Directed stimulus row; exp is used only when typed is set
   typedef struct {
      logic [ACT_W-1:0]      action;
      logic [KEY_W-1:0]      entity;
      logic [DATA_WIDTH-1:0] value;
      bit                    typed;
      res_type               exp;
   } dir_row_type;

   // Shadow copy of the table
   logic [KEY_W-1:0]      shadow_keys [TABLE_DEPTH];
   logic [DATA_WIDTH-1:0] shadow_vals [TABLE_DEPTH];
   int                    shadow_count = 0;

   res_type     pending_results [$];
   dir_row_type dir_rows [$];
   int          error_count = 0;
   int          items_sent  = 0;
   int          snd_idle_pct = 16;
   int          rcv_idle_pct = 54;
   int          stall_cycles = 0;

   logic [KEY_W-1:0] key_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                      16'h00A5, 16'h1234, 16'h7FFF, 16'h5555};

   // Clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Apply one request to the shadow table and return the response it causes
   function automatic res_type predict_table_op(req_type r);
      res_type o;
      int      hit;
      o   = '0;
      hit = -1;
      if (r.action == ACT_LOOKUP || r.action == ACT_REMOVE) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_keys[i] == r.entity) hit = i;
         end
      end
      case (r.action)
         ACT_ADD: begin
            if (shadow_count >= TABLE_DEPTH) begin
               o.status = STAT_FULL;
            end else begin
               shadow_keys[shadow_count] = r.entity;
               shadow_vals[shadow_count] = r.value;
               shadow_count++;
               o.found = 1'b1;
            end
         end
         ACT_LOOKUP: begin
            if (hit < 0) begin
               o.status = STAT_MISS;
            end else begin
               o.found     = 1'b1;
               o.value_out = shadow_vals[hit];
            end
         end
         ACT_REMOVE: begin
            if (hit < 0) begin
               o.status = STAT_MISS;
            end else begin
               // last entry swaps into the hole
               shadow_keys[hit] = shadow_keys[shadow_count-1];
               shadow_vals[hit] = shadow_vals[shadow_count-1];
               shadow_count--;
               o.found = 1'b1;
            end
         end
         default: o.status = STAT_OK;
      endcase
      o.count = CNT_W'(shadow_count);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got_v,
                                  input longint unsigned exp_v);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got_v, exp_v,
               $realtime);
      error_count++;
   endtask

   // Send one request; record its expected response at acceptance
   task automatic issue_request(input req_type r, input bit typed, input res_type typed_res);
      res_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r};
      do @(posedge clock); while (!req_tready);
      predicted = predict_table_op(r);
      pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic issue_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key);
      req_type r;
      r.action = act;
      r.entity = key;
      r.value  = $urandom;
      issue_request(r, 1'b0, '0);
   endtask

   // Hold the sender until every outstanding response has arrived
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                          input logic [DATA_WIDTH-1:0] val, input bit typed,
                          input logic fnd, input logic [DATA_WIDTH-1:0] vout,
                          input logic [STAT_W-1:0] st, input int cnt);
      dir_row_type row;
      row.action          = act;
      row.entity          = key;
      row.value           = val;
      row.typed           = typed;
      row.exp.found       = fnd;
      row.exp.value_out   = vout;
      row.exp.status      = st;
      row.exp.count       = CNT_W'(cnt);
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // Key choice: mostly keys held in the table when preferred, then a small pool, rarely any key
   function automatic logic [KEY_W-1:0] pick_key(input bit prefer_stored);
      if (prefer_stored && shadow_count > 0 && $urandom_range(99) < 75)
         return shadow_keys[$urandom_range(shadow_count - 1)];
      if ($urandom_range(9) == 0)
         return KEY_W'($urandom);
      return key_pool[$urandom_range(7)];
   endfunction

   function automatic logic [ACT_W-1:0] pick_mixed_action();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return ACT_ADD;
      if (roll < 70) return ACT_LOOKUP;
      if (roll < 95) return ACT_REMOVE;
      return ACT_NOP;
   endfunction

   // Receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Response checker
   always @(posedge clock) begin
      res_type got;
      res_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = res_type'(rsp_tdata[41:0]);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 0);
         end else begin
            exp = pending_results.pop_front();
            if (got.found !== exp.found)
               report_mismatch("found", got.found, exp.found);
            if (got.value_out !== exp.value_out)
               report_mismatch("value_out", got.value_out, exp.value_out);
            if (got.status !== exp.status)
               report_mismatch("status", got.status, exp.status);
            if (got.count !== exp.count)
               report_mismatch("count", got.count, exp.count);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("packed_keyed_table_swap_remove_top verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      int      kind;
      int      n;
      bit      first_seq;
      req_type r;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, no-op, extremes, duplicates, swap-remove, last-entry remove
      add_row(ACT_LOOKUP, 16'h0001, 32'h0,        1, 0, 32'h0,        STAT_MISS, 0);
      add_row(ACT_REMOVE, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_MISS, 0);
      add_row(ACT_NOP,    16'hFFFF, 32'hFFFFFFFF, 1, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_ADD,    16'h0000, 32'h0,        1, 1, 32'h0,        STAT_OK,   1);
      add_row(ACT_ADD,    16'hFFFF, 32'hFFFFFFFF, 1, 1, 32'h0,        STAT_OK,   2);
      add_row(ACT_LOOKUP, 16'hFFFF, 32'h0,        1, 1, 32'hFFFFFFFF, STAT_OK,   2);
      add_row(ACT_LOOKUP, 16'h0000, 32'hFFFFFFFF, 1, 1, 32'h0,        STAT_OK,   2);
      add_row(ACT_REMOVE, 16'hFFFF, 32'h0,        1, 1, 32'h0,        STAT_OK,   1);
      add_row(ACT_LOOKUP, 16'hFFFF, 32'h0,        1, 0, 32'h0,        STAT_MISS, 1);
      add_row(ACT_ADD,    16'hFFFF, 32'h12345678, 0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_ADD,    16'hFFFF, 32'h80000001, 0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_ADD,    16'h00A5, 32'h5A5A5A5A, 0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_LOOKUP, 16'hFFFF, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_REMOVE, 16'h0000, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_LOOKUP, 16'h00A5, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_NOP,    16'h00A5, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_REMOVE, 16'hFFFF, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_LOOKUP, 16'hFFFF, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_REMOVE, 16'h7777, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_REMOVE, 16'h00A5, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_REMOVE, 16'hFFFF, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);
      add_row(ACT_REMOVE, 16'hFFFF, 32'h0,        0, 0, 32'h0,        STAT_OK,   0);

      foreach (dir_rows[i]) begin
         r.action = dir_rows[i].action;
         r.entity = dir_rows[i].entity;
         r.value  = dir_rows[i].value;
         issue_request(r, dir_rows[i].typed, dir_rows[i].exp);
      end
      hold_until_drained();

      // Random: fill, drain and mixed runs; the first run fills the table
      items_sent = 0;
      first_seq  = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            snd_idle_pct = 54;
            rcv_idle_pct = 16;
         end
         kind = first_seq ? 0 : $urandom_range(3);
         case (kind)
            0: begin
               // fill to full, then adds that must be refused
               while (shadow_count < TABLE_DEPTH) begin
                  if ($urandom_range(9) == 0) issue_op(ACT_LOOKUP, pick_key(1));
                  else issue_op(ACT_ADD, pick_key(0));
               end
               n = $urandom_range(1, 3);
               repeat (n) issue_op(ACT_ADD, pick_key(0));
            end
            1: begin
               // drain to empty, then a remove and a lookup on the empty table
               while (shadow_count > 0) issue_op(ACT_REMOVE, pick_key(1));
               issue_op(ACT_REMOVE, pick_key(1));
               issue_op(ACT_LOOKUP, pick_key(0));
            end
            default: begin
               n = $urandom_range(5, 30);
               repeat (n) issue_op(pick_mixed_action(), pick_key(1));
            end
         endcase
         if (first_seq || $urandom_range(3) == 0) hold_until_drained();
         first_seq = 1'b0;
      end

      // Wind down
      req_tvalid   <= 1'b0;
      rcv_idle_pct = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses left outstanding", pending_results.size(), 0);

      if (error_count == 0) begin
         $display("packed_keyed_table_swap_remove_top verification clean");
      end else begin
         $display("packed_keyed_table_swap_remove_top verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/pkts_pkg.sv
rtl/pkts_store.sv
rtl/pkts_seq.sv
rtl/packed_keyed_table_swap_remove_top.sv
verif/packed_keyed_table_swap_remove_top_tb.sv
